FILE: hw/rtl/ga_og_pkg.sv
package ga_og_pkg;

  // Population geometry.
  localparam int POP_SIZE     = 64;
  localparam int GENOME_BYTES = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Derived sizes.
  localparam int SLOT_W      = $clog2(POP_SIZE);
  localparam int STORE_DEPTH = POP_SIZE * GENOME_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int GENE_BITS   = 4 * GENOME_BYTES;
  localparam int GIDX_W      = $clog2(GENE_BITS);
  localparam int BYTE_W      = (GENOME_BYTES > 1) ? $clog2(GENOME_BYTES) : 1;
  localparam int KEY_W       = 32;
  localparam int GENE_W      = 8;

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    REQ_LOAD_GENE = 2'd0,
    REQ_LOAD_KEY  = 2'd1,
    REQ_BREED     = 2'd2,
    REQ_NONE      = 2'd3
  } req_e;

  // Command kinds carried through the queue.
  typedef enum logic [1:0] {
    CMD_LOAD_GENE,
    CMD_LOAD_KEY,
    CMD_BREED,
    CMD_REDRAW
  } cmd_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS_A,
    ST_KEYS_B,
    ST_EMIT
  } state_e;

  // One classified command.
  typedef struct packed {
    cmd_e                kind;
    logic [STORE_AW-1:0] gaddr;
    logic [SLOT_W-1:0]   saddr;
    logic [KEY_W-1:0]    data;
    logic [SLOT_W-1:0]   a1;
    logic [SLOT_W-1:0]   a2;
    logic [SLOT_W-1:0]   b1;
    logic [SLOT_W-1:0]   b2;
    logic [GIDX_W-1:0]   cut;
    logic [GIDX_W-1:0]   m1;
    logic [GIDX_W-1:0]   m2;
  } cmd_t;

  // Exact floor(r * top / 255) for 8-bit r and top, using the reciprocal
  // 257 / 65536 with a one-count correction.
  function automatic logic [7:0] scale_draw(input logic [7:0] r, input logic [7:0] top);
    logic [15:0] prod;
    logic [16:0] inc;
    logic [24:0] sum;
    prod = 16'(r) * 16'(top);
    inc  = 17'(prod) + 17'd1;
    sum  = {inc, 8'b0} + 25'(inc);
    return sum[23:16];
  endfunction

endpackage

FILE: hw/rtl/ga_og_req_if.sv
interface ga_og_req_if;

  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  slot;
  logic [4:0]  byte_pos;
  logic [7:0]  gene_byte;
  logic [31:0] fitness_key;
  logic [7:0]  rand_a1;
  logic [7:0]  rand_a2;
  logic [7:0]  rand_b1;
  logic [7:0]  rand_b2;
  logic [7:0]  rand_cut;
  logic [7:0]  rand_mut_one;
  logic [7:0]  rand_mut_two;

  modport source (
    output valid, req_type, slot, byte_pos, gene_byte, fitness_key,
    output rand_a1, rand_a2, rand_b1, rand_b2, rand_cut, rand_mut_one, rand_mut_two,
    input  ready
  );

  modport sink (
    input  valid, req_type, slot, byte_pos, gene_byte, fitness_key,
    input  rand_a1, rand_a2, rand_b1, rand_b2, rand_cut, rand_mut_one, rand_mut_two,
    output ready
  );

endinterface

FILE: hw/rtl/ga_og_res_if.sv
interface ga_og_res_if;

  logic       valid;
  logic       ready;
  logic       child_sel;
  logic [4:0] out_pos;
  logic [7:0] child_byte;
  logic [5:0] parent_one;
  logic [5:0] parent_two;
  logic       redraw;
  logic       last;

  modport source (
    output valid, child_sel, out_pos, child_byte, parent_one, parent_two, redraw, last,
    input  ready
  );

  modport sink (
    input  valid, child_sel, out_pos, child_byte, parent_one, parent_two, redraw, last,
    output ready
  );

endinterface

FILE: hw/rtl/ga_og_ram.sv
module ga_og_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, two registered read ports that hold while not enabled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

FILE: hw/rtl/ga_og_front.sv
module ga_og_front (
  ga_og_req_if.sink         req_i,
  input  logic              full_i,
  output logic              push_o,
  output ga_og_pkg::cmd_t   cmd_o
);

  import ga_og_pkg::*;

  logic slot_ok;
  logic pos_ok;
  logic accept;

  assign req_i.ready = !full_i;
  assign accept      = req_i.valid && !full_i;
  assign slot_ok     = 32'(req_i.slot) < POP_SIZE;
  assign pos_ok      = 32'(req_i.byte_pos) < GENOME_BYTES;

  // Scaled draws and store addresses are worked out here, once per transaction,
  // and the request is then classified; out-of-range loads and the unused code
  // are dropped.
  always_comb begin
    cmd_o.gaddr = STORE_AW'(32'(req_i.slot) * GENOME_BYTES + 32'(req_i.byte_pos));
    cmd_o.saddr = SLOT_W'(req_i.slot);
    if (req_e'(req_i.req_type) == REQ_LOAD_GENE) begin
      cmd_o.data = KEY_W'(req_i.gene_byte);
    end else begin
      cmd_o.data = req_i.fitness_key;
    end
    cmd_o.a1    = SLOT_W'(scale_draw(req_i.rand_a1, 8'(POP_SIZE - 1)));
    cmd_o.a2    = SLOT_W'(scale_draw(req_i.rand_a2, 8'(POP_SIZE - 1)));
    cmd_o.b1    = SLOT_W'(scale_draw(req_i.rand_b1, 8'(POP_SIZE - 1)));
    cmd_o.b2    = SLOT_W'(scale_draw(req_i.rand_b2, 8'(POP_SIZE - 1)));
    cmd_o.cut   = GIDX_W'(scale_draw(req_i.rand_cut, 8'(GENE_BITS - 1)));
    cmd_o.m1    = GIDX_W'(scale_draw(req_i.rand_mut_one, 8'(GENE_BITS - 1)));
    cmd_o.m2    = GIDX_W'(scale_draw(req_i.rand_mut_two, 8'(GENE_BITS - 1)));

    push_o     = 1'b0;
    cmd_o.kind = CMD_BREED;
    unique case (req_e'(req_i.req_type))
      REQ_LOAD_GENE: begin
        cmd_o.kind = CMD_LOAD_GENE;
        push_o     = accept && slot_ok && pos_ok;
      end
      REQ_LOAD_KEY: begin
        cmd_o.kind = CMD_LOAD_KEY;
        push_o     = accept && slot_ok;
      end
      REQ_BREED: begin
        if ((cmd_o.a1 == cmd_o.a2) || (cmd_o.b1 == cmd_o.b2)) begin
          cmd_o.kind = CMD_REDRAW;
        end else begin
          cmd_o.kind = CMD_BREED;
        end
        push_o = accept;
      end
      REQ_NONE: begin
        push_o = 1'b0;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/ga_og_queue.sv
module ga_og_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ga_og_pkg::cmd_t data_i,
  input  logic            pop_i,
  output ga_og_pkg::cmd_t data_o,
  output logic            full_o,
  output logic            empty_o
);

  import ga_og_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");
`endif

endmodule

FILE: hw/rtl/ga_og_back.sv
module ga_og_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ga_og_pkg::cmd_t   cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  ga_og_res_if.source       res_o
);

  import ga_og_pkg::*;

  // Byte read stage payload.
  typedef struct packed {
    logic              redraw;
    logic              child;
    logic [BYTE_W-1:0] pos;
    logic              last;
    logic [GIDX_W-1:0] cut;
    logic [GIDX_W-1:0] mq;
    logic [SLOT_W-1:0] p1;
    logic [SLOT_W-1:0] p2;
  } s1_t;

  state_e state_q, state_d;

  cmd_t              cmd_q;
  logic [SLOT_W-1:0] w1_q, w2_q;
  logic [BYTE_W-1:0] pos_q;
  logic              child_q;
  logic              s1_vld_q;
  s1_t               s1_q, s1_d;
  logic              out_vld_q;

  logic                stall_n;
  logic                last_issue;
  logic                issue_byte;
  logic                issue_redraw;
  logic                gram_we, gram_re;
  logic                fram_we, fram_re;
  logic [SLOT_W-1:0]   fram_ra0, fram_ra1;
  logic [SLOT_W-1:0]   own_slot, oth_slot;
  logic [STORE_AW-1:0] own_addr, oth_addr;
  logic [GENE_W-1:0]   own_byte, oth_byte;
  logic [KEY_W-1:0]    key0, key1;
  logic [SLOT_W-1:0]   key_winner;

  logic [BYTE_W-1:0] cut_byte;
  logic [7:0]        cut_mask;
  logic [7:0]        mixed;
  logic [7:0]        child_val;

  assign stall_n    = !out_vld_q || res_o.ready;
  assign last_issue = child_q && (pos_q == BYTE_W'(GENOME_BYTES - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind == CMD_BREED) begin
          state_d = ST_KEYS_A;
        end
      end
      ST_KEYS_A: state_d = ST_KEYS_B;
      ST_KEYS_B: state_d = ST_EMIT;
      ST_EMIT: begin
        if (stall_n && last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_pop_o    = 1'b0;
    gram_we      = 1'b0;
    gram_re      = 1'b0;
    fram_we      = 1'b0;
    fram_re      = 1'b0;
    fram_ra0     = cmd_q.b1;
    fram_ra1     = cmd_q.b2;
    issue_byte   = 1'b0;
    issue_redraw = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        fram_ra0 = cmd_i.a1;
        fram_ra1 = cmd_i.a2;
        if (!cmd_empty_i) begin
          unique case (cmd_i.kind)
            CMD_LOAD_GENE: begin
              cmd_pop_o = 1'b1;
              gram_we   = 1'b1;
            end
            CMD_LOAD_KEY: begin
              cmd_pop_o = 1'b1;
              fram_we   = 1'b1;
            end
            CMD_BREED: begin
              cmd_pop_o = 1'b1;
              fram_re   = 1'b1;
            end
            CMD_REDRAW: begin
              cmd_pop_o    = stall_n;
              issue_redraw = stall_n;
            end
            default: cmd_pop_o = 1'b0;
          endcase
        end
      end
      ST_KEYS_A: fram_re = 1'b1;
      ST_KEYS_B: fram_re = 1'b0;
      ST_EMIT: begin
        gram_re    = stall_n;
        issue_byte = stall_n;
      end
      default: cmd_pop_o = 1'b0;
    endcase
  end

  // Store addresses for the byte being read.
  assign own_slot = child_q ? w2_q : w1_q;
  assign oth_slot = child_q ? w1_q : w2_q;
  assign own_addr = STORE_AW'(32'(own_slot) * GENOME_BYTES + 32'(pos_q));
  assign oth_addr = STORE_AW'(32'(oth_slot) * GENOME_BYTES + 32'(pos_q));

  ga_og_ram #(
    .WIDTH (GENE_W),
    .DEPTH (STORE_DEPTH)
  ) u_genome_ram (
    .clk_i    (clk_i),
    .we_i     (gram_we),
    .waddr_i  (cmd_i.gaddr),
    .wdata_i  (GENE_W'(cmd_i.data)),
    .re_i     (gram_re),
    .raddr0_i (own_addr),
    .raddr1_i (oth_addr),
    .rdata0_o (own_byte),
    .rdata1_o (oth_byte)
  );

  ga_og_ram #(
    .WIDTH (KEY_W),
    .DEPTH (POP_SIZE)
  ) u_fitness_ram (
    .clk_i    (clk_i),
    .we_i     (fram_we),
    .waddr_i  (cmd_i.saddr),
    .wdata_i  (cmd_i.data),
    .re_i     (fram_re),
    .raddr0_i (fram_ra0),
    .raddr1_i (fram_ra1),
    .rdata0_o (key0),
    .rdata1_o (key1)
  );

  // Tournament: the first contestant wins only on a strictly lower key.
  always_comb begin
    if (state_q == ST_KEYS_A) begin
      key_winner = (key0 < key1) ? cmd_q.a1 : cmd_q.a2;
    end else begin
      key_winner = (key0 < key1) ? cmd_q.b1 : cmd_q.b2;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stall_n) begin
        s1_vld_q  <= issue_byte || issue_redraw;
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Read stage payload for the next byte or the redraw result.
  always_comb begin
    s1_d.redraw = issue_redraw;
    s1_d.child  = child_q;
    s1_d.pos    = pos_q;
    s1_d.last   = issue_redraw || last_issue;
    s1_d.cut    = cmd_q.cut;
    s1_d.mq     = child_q ? cmd_q.m2 : cmd_q.m1;
    s1_d.p1     = w1_q;
    s1_d.p2     = w2_q;
  end

  // Breed datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && state_d == ST_KEYS_A) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_KEYS_A) begin
      w1_q <= key_winner;
    end
    if (state_q == ST_KEYS_B) begin
      w2_q    <= key_winner;
      pos_q   <= '0;
      child_q <= 1'b0;
    end else if (issue_byte) begin
      if (pos_q == BYTE_W'(GENOME_BYTES - 1)) begin
        pos_q   <= '0;
        child_q <= 1'b1;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
    if (stall_n) begin
      s1_q <= s1_d;
    end
  end

  // Crossover and mutation of the byte in the read stage.
  always_comb begin
    cut_byte  = BYTE_W'(s1_q.cut >> 2);
    cut_mask  = ~(8'hFF >> s1_q.cut[1:0]);
    mixed     = (own_byte & cut_mask) | (oth_byte & ~cut_mask);
    if (s1_q.pos < cut_byte) begin
      child_val = own_byte;
    end else if (s1_q.pos > cut_byte) begin
      child_val = oth_byte;
    end else begin
      child_val = mixed;
    end
    if (s1_q.pos == BYTE_W'(s1_q.mq >> 2)) begin
      child_val = child_val ^ (8'h80 >> s1_q.mq[1:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (stall_n) begin
      res_o.redraw <= s1_q.redraw;
      res_o.last   <= s1_q.last;
      if (s1_q.redraw) begin
        res_o.child_sel  <= 1'b0;
        res_o.out_pos    <= '0;
        res_o.child_byte <= '0;
        res_o.parent_one <= '0;
        res_o.parent_two <= '0;
      end else begin
        res_o.child_sel  <= s1_q.child;
        res_o.out_pos    <= 5'(s1_q.pos);
        res_o.child_byte <= child_val;
        res_o.parent_one <= 6'(s1_q.p1);
        res_o.parent_two <= 6'(s1_q.p2);
      end
    end
  end

  assign res_o.valid = out_vld_q;

`ifndef SYNTH
  a_redraw_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_o.redraw |-> res_o.last)
    else $error("redraw result without last");
  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == ST_IDLE)
    else $error("command popped outside idle");
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !stall_n |=> s1_vld_q)
    else $error("read stage lost a byte under stall");
`endif

endmodule

FILE: hw/rtl/ga_offspring_generator.sv
// Offspring generator for a genetic algorithm.
// Requests arrive on req_i (valid/ready). A genome load writes one byte and a
// fitness load writes one key of the population store; loads produce no
// transaction on res_o. A breed request runs two binary tournaments, crosses
// the winners over at one bit and flips one gene bit in each child, then
// sends child one bytes 0..GENOME_BYTES-1 and child two bytes the same way on
// res_o, with last on the final byte. A tournament that draws one slot twice
// gives a single redraw transaction instead.
// Requests pass through a two-entry command queue, so the front keeps taking
// requests while the back is busy. The back handles one command at a time: a
// load is written from idle; a breed reads two pairs of fitness keys, then one
// genome byte per cycle while the output does not stall. With the back idle, a
// breed passes the queue, the key and emit states, the read stage and the
// output register before its first child byte is valid; a redraw skips the key
// and emit states. When the receiver holds ready low, the output register and
// the read stage hold their bytes and the sequencer waits; the queue then fills
// and req_i ready drops. Reset empties the queue and the pipeline; the stores
// are not cleared and must be loaded before a breed reads them.
module ga_offspring_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  ga_og_req_if.sink   req_i,
  ga_og_res_if.source res_o
);

  import ga_og_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  ga_og_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  ga_og_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  ga_og_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .res_o       (res_o)
  );

endmodule
